// File: rtl/spa_pkg.sv
// Shared constants, types and helper functions of the stack pool allocator.
`default_nettype none
package spa_pkg;

    // Pool geometry
    localparam int POOL_WORDS      = 256;
    localparam int WORD_BYTES_LOG2 = 2;
    localparam int WORD_BYTES      = 1 << WORD_BYTES_LOG2;
    localparam int MEM_DEPTH       = POOL_WORDS + 1;

    // Field widths
    localparam int ADDR_W   = $clog2(MEM_DEPTH);
    localparam int BYTE_W   = 11;
    localparam int STATUS_W = 2;
    // Width of the count of words taken by one block, header included
    localparam int NEED_W   = BYTE_W - WORD_BYTES_LOG2 + 1;
    // Width of top + words needed
    localparam int SUM_W    = ((ADDR_W > NEED_W) ? ADDR_W : NEED_W) + 1;

    // Operation codes
    localparam logic FN_ALLOC = 1'b0;
    localparam logic FN_FREE  = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_ALLOC     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_ROOM   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FREED     = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_OWNED = 2'd3;

    // One header word of the pool
    typedef struct packed {
        logic [ADDR_W-1:0] back;
        logic [BYTE_W-1:0] size;
    } t_hdr;

    // Header memory access from the engine
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        t_hdr              wdata;
        logic [ADDR_W-1:0] raddr;
    } t_mem_req;

    // Finished result of one item
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ADDR_W-1:0]   block_address;
        logic [BYTE_W-1:0]   block_bytes;
        logic [ADDR_W-1:0]   top_word;
        logic [BYTE_W-1:0]   live_bytes;
        logic [BYTE_W-1:0]   reserved_bytes;
    } t_result;

    // Words a block of b bytes occupies, header included
    function automatic logic [NEED_W-1:0] words_needed(input logic [BYTE_W-1:0] b);
        logic [BYTE_W:0] sum;
        sum = {1'b0, b} + (BYTE_W+1)'(WORD_BYTES - 1);
        return NEED_W'(sum >> WORD_BYTES_LOG2) + NEED_W'(1);
    endfunction

    // Bytes reserved for a block of b bytes, modulo the total width
    function automatic logic [BYTE_W-1:0] reserve_bytes(input logic [BYTE_W-1:0] b);
        logic [NEED_W+WORD_BYTES_LOG2-1:0] w;
        w = (NEED_W+WORD_BYTES_LOG2)'(words_needed(b)) << WORD_BYTES_LOG2;
        return w[BYTE_W-1:0];
    endfunction

    // Previous header index, clamped at zero
    function automatic logic [ADDR_W-1:0] prev_header(input logic [ADDR_W-1:0] h,
                                                      input logic [ADDR_W-1:0] back);
        return (h >= back) ? (h - back) : '0;
    endfunction

endpackage
`default_nettype wire

// File: rtl/spa_in_if.sv
// Request channel of the stack pool allocator.
`default_nettype none
interface spa_in_if;
    logic                      valid;
    logic                      ready;
    logic                      func;
    logic [spa_pkg::BYTE_W-1:0] byte_count;
    logic [spa_pkg::ADDR_W-1:0] word_address;

    modport source (output valid, func, byte_count, word_address, input ready);
    modport sink   (input valid, func, byte_count, word_address, output ready);
endinterface
`default_nettype wire

// File: rtl/spa_out_if.sv
// Result channel of the stack pool allocator.
`default_nettype none
interface spa_out_if;
    logic                         valid;
    logic                         ready;
    logic [spa_pkg::STATUS_W-1:0] status;
    logic [spa_pkg::ADDR_W-1:0]   block_address;
    logic [spa_pkg::BYTE_W-1:0]   block_bytes;
    logic [spa_pkg::ADDR_W-1:0]   top_word;
    logic [spa_pkg::BYTE_W-1:0]   live_bytes;
    logic [spa_pkg::BYTE_W-1:0]   reserved_bytes;

    modport source (output valid, status, block_address, block_bytes, top_word,
                    live_bytes, reserved_bytes, input ready);
    modport sink   (input valid, status, block_address, block_bytes, top_word,
                    live_bytes, reserved_bytes, output ready);
endinterface
`default_nettype wire

// File: rtl/spa_hdr_store.sv
// Header memory of the pool with its clearing sweep after reset.
`default_nettype none
module spa_hdr_store (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire spa_pkg::t_mem_req i_req,
    output spa_pkg::t_hdr          o_rdata,
    output logic                   o_clearing
);

    spa_pkg::t_hdr                  r_mem [spa_pkg::MEM_DEPTH];
    spa_pkg::t_hdr                  r_rdata;
    logic                           r_clearing;
    logic [spa_pkg::ADDR_W-1:0]     r_clr_idx;

    logic                           wen;
    logic [spa_pkg::ADDR_W-1:0]     waddr;
    spa_pkg::t_hdr                  wdata;

    // Sweep has the write port until every entry is zero
    assign wen   = r_clearing | i_req.we;
    assign waddr = r_clearing ? r_clr_idx : i_req.waddr;
    assign wdata = r_clearing ? '0 : i_req.wdata;

    // Clearing sweep, one entry a cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_idx  <= '0;
        end else if (r_clearing) begin
            if (r_clr_idx == spa_pkg::ADDR_W'(spa_pkg::MEM_DEPTH - 1)) begin
                r_clearing <= 1'b0;
            end else begin
                r_clr_idx <= r_clr_idx + spa_pkg::ADDR_W'(1);
            end
        end
    end

    // Memory: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (wen) begin
            r_mem[waddr] <= wdata;
        end
        r_rdata <= r_mem[i_req.raddr];
    end

    assign o_rdata    = r_rdata;
    assign o_clearing = r_clearing;

    // Sweep index never leaves the memory
    a_clr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clearing |-> (r_clr_idx <= spa_pkg::ADDR_W'(spa_pkg::MEM_DEPTH - 1)))
        else $error("clear index out of range");

    // Engine does not write while the sweep runs
    a_no_write_clr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.we |-> !r_clearing)
        else $error("engine write during clearing");

    // Sweep ends only after the last entry
    a_clr_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_clearing) |->
            ($past(r_clr_idx) == spa_pkg::ADDR_W'(spa_pkg::MEM_DEPTH - 1)))
        else $error("clearing ended early");

endmodule
`default_nettype wire

// File: rtl/spa_engine.sv
// Allocate / free sequencer: reads, modifies and writes back pool headers.
`default_nettype none
module spa_engine (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    spa_in_if.sink                 i_in,
    input  wire spa_pkg::t_hdr     i_rdata,
    input  wire logic              i_clearing,
    input  wire logic              i_take,
    output spa_pkg::t_mem_req      o_mem_req,
    output logic                   o_res_valid,
    output spa_pkg::t_result       o_res
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ALLOC_RD,
        S_ALLOC_WR,
        S_FREE_HDR,
        S_FREE_TOP,
        S_WALK,
        S_FIN
    } t_state;

    t_state                         r_state, n_state;
    logic [spa_pkg::ADDR_W-1:0]     r_top, n_top;
    logic [spa_pkg::BYTE_W-1:0]     r_live, n_live;
    logic [spa_pkg::BYTE_W-1:0]     r_resv, n_resv;
    logic [spa_pkg::BYTE_W-1:0]     r_bytes, n_bytes;
    logic [spa_pkg::ADDR_W-1:0]     r_n, n_n;
    logic [spa_pkg::ADDR_W-1:0]     r_next, n_next;
    logic [spa_pkg::ADDR_W-1:0]     r_h, n_h;
    logic [spa_pkg::ADDR_W-1:0]     r_t, n_t;
    spa_pkg::t_hdr                  r_hdr, n_hdr;
    logic [spa_pkg::STATUS_W-1:0]   r_status, n_status;
    logic [spa_pkg::ADDR_W-1:0]     r_blk_addr, n_blk_addr;
    logic [spa_pkg::BYTE_W-1:0]     r_blk_bytes, n_blk_bytes;

    logic                           in_ready;
    logic [spa_pkg::NEED_W-1:0]     alloc_n;
    logic [spa_pkg::SUM_W-1:0]      alloc_sum;
    logic [spa_pkg::ADDR_W-1:0]     top_prev;
    logic [spa_pkg::ADDR_W-1:0]     walk_prev;

    assign in_ready   = (r_state == S_IDLE) && !i_clearing;
    assign i_in.ready = in_ready;

    // Size of the requested block and the new top
    assign alloc_n   = spa_pkg::words_needed(i_in.byte_count);
    assign alloc_sum = spa_pkg::SUM_W'(r_top) + spa_pkg::SUM_W'(alloc_n);

    // Header below the top, and the next step of the pop walk
    assign top_prev  = spa_pkg::prev_header(r_top, i_rdata.back);
    assign walk_prev = spa_pkg::prev_header(r_t, i_rdata.back);

    // Next-state and memory access logic
    always_comb begin
        n_state     = r_state;
        n_top       = r_top;
        n_live      = r_live;
        n_resv      = r_resv;
        n_bytes     = r_bytes;
        n_n         = r_n;
        n_next      = r_next;
        n_h         = r_h;
        n_t         = r_t;
        n_hdr       = r_hdr;
        n_status    = r_status;
        n_blk_addr  = r_blk_addr;
        n_blk_bytes = r_blk_bytes;
        o_mem_req   = '0;

        case (r_state)
            S_IDLE: begin
                if (i_in.valid && in_ready) begin
                    n_bytes     = i_in.byte_count;
                    n_blk_addr  = '0;
                    n_blk_bytes = '0;
                    if (i_in.func == spa_pkg::FN_ALLOC) begin
                        if (alloc_sum <= spa_pkg::SUM_W'(spa_pkg::POOL_WORDS)) begin
                            n_n             = spa_pkg::ADDR_W'(alloc_n);
                            n_next          = spa_pkg::ADDR_W'(alloc_sum);
                            o_mem_req.raddr = r_top;
                            n_state         = S_ALLOC_RD;
                        end else begin
                            n_status = spa_pkg::ST_NO_ROOM;
                            n_state  = S_FIN;
                        end
                    end else if (i_in.word_address == '0 ||
                                 i_in.word_address >=
                                     spa_pkg::ADDR_W'(spa_pkg::POOL_WORDS)) begin
                        n_status = spa_pkg::ST_NOT_OWNED;
                        n_state  = S_FIN;
                    end else begin
                        n_h             = i_in.word_address - spa_pkg::ADDR_W'(1);
                        o_mem_req.raddr = i_in.word_address - spa_pkg::ADDR_W'(1);
                        n_state         = S_FREE_HDR;
                    end
                end
            end
            // Old top header: keep its back offset, set its size
            S_ALLOC_RD: begin
                o_mem_req.we         = 1'b1;
                o_mem_req.waddr      = r_top;
                o_mem_req.wdata.back = i_rdata.back;
                o_mem_req.wdata.size = r_bytes;
                n_state              = S_ALLOC_WR;
            end
            // New empty top header
            S_ALLOC_WR: begin
                o_mem_req.we         = 1'b1;
                o_mem_req.waddr      = r_next;
                o_mem_req.wdata.back = r_n;
                o_mem_req.wdata.size = '0;
                n_blk_addr           = r_top + spa_pkg::ADDR_W'(1);
                n_blk_bytes          = r_bytes;
                n_top                = r_next;
                n_live               = r_live + r_bytes;
                n_resv               = r_resv + spa_pkg::reserve_bytes(r_bytes);
                n_status             = spa_pkg::ST_ALLOC;
                n_state              = S_FIN;
            end
            // Header of the freed block is in; reject it if already free, else fetch the top header
            S_FREE_HDR: begin
                if (i_rdata.size == '0) begin
                    n_status = spa_pkg::ST_NOT_OWNED;
                    n_state  = S_FIN;
                end else begin
                    n_hdr           = i_rdata;
                    o_mem_req.raddr = r_top;
                    n_state         = S_FREE_TOP;
                end
            end
            // Release the block; pop the top when it sits just below
            S_FREE_TOP: begin
                o_mem_req.we         = 1'b1;
                o_mem_req.waddr      = r_h;
                o_mem_req.wdata.back = r_hdr.back;
                o_mem_req.wdata.size = '0;
                n_blk_bytes          = r_hdr.size;
                n_live               = r_live - r_hdr.size;
                n_resv               = r_resv - spa_pkg::reserve_bytes(r_hdr.size);
                n_status             = spa_pkg::ST_FREED;
                if (r_h != top_prev) begin
                    n_state = S_FIN;
                end else begin
                    n_top = r_h;
                    if (r_h == '0 || r_hdr.back == '0) begin
                        n_state = S_FIN;
                    end else begin
                        n_t             = spa_pkg::prev_header(r_h, r_hdr.back);
                        o_mem_req.raddr = spa_pkg::prev_header(r_h, r_hdr.back);
                        n_state         = S_WALK;
                    end
                end
            end
            // Pop over headers that are already free, one a cycle
            S_WALK: begin
                if (i_rdata.size != '0) begin
                    n_state = S_FIN;
                end else begin
                    n_top = r_t;
                    if (r_t == '0 || i_rdata.back == '0) begin
                        n_state = S_FIN;
                    end else begin
                        n_t             = walk_prev;
                        o_mem_req.raddr = walk_prev;
                    end
                end
            end
            S_FIN: begin
                if (i_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State, pool totals and working registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_top   <= '0;
            r_live  <= '0;
            r_resv  <= '0;
        end else begin
            r_state <= n_state;
            r_top   <= n_top;
            r_live  <= n_live;
            r_resv  <= n_resv;
        end
        r_bytes     <= n_bytes;
        r_n         <= n_n;
        r_next      <= n_next;
        r_h         <= n_h;
        r_t         <= n_t;
        r_hdr       <= n_hdr;
        r_status    <= n_status;
        r_blk_addr  <= n_blk_addr;
        r_blk_bytes <= n_blk_bytes;
    end

    assign o_res_valid          = (r_state == S_FIN);
    assign o_res.status         = r_status;
    assign o_res.block_address  = r_blk_addr;
    assign o_res.block_bytes    = r_blk_bytes;
    assign o_res.top_word       = r_top;
    assign o_res.live_bytes     = r_live;
    assign o_res.reserved_bytes = r_resv;

    // Top stays inside the pool
    a_top_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_top <= spa_pkg::ADDR_W'(spa_pkg::POOL_WORDS))
        else $error("top beyond pool");

    // Pop walk always moves below the current top
    a_walk_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> (r_t < r_top))
        else $error("pop walk not below top");

    // Only a successful allocate reports a block address
    a_addr_alloc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && r_status != spa_pkg::ST_ALLOC) |-> (r_blk_addr == '0))
        else $error("block address on non-allocate result");

endmodule
`default_nettype wire

// File: rtl/stack_pool_allocator.sv
// Allocate: reads the old top header, writes it back with the block size, then writes
// a new empty top header. No room / free out of range: straight from idle to the result.
// Free of a block with size zero: result once its header has been read.
// Free: reads the block and top headers, then pops over free headers; one item at a time.
// Reset (synchronous, active low) zeroes top and totals, then sweeps the
// 257-entry header memory before the first item is taken.
`default_nettype none
module stack_pool_allocator (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    spa_in_if.sink    i_in,
    spa_out_if.source o_out
);

    spa_pkg::t_mem_req mem_req;
    spa_pkg::t_hdr     rdata;
    logic              clearing;
    logic              res_valid;
    spa_pkg::t_result  res;
    logic              take;

    logic              r_out_valid;
    spa_pkg::t_result  r_out;

    spa_hdr_store u_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (mem_req),
        .o_rdata    (rdata),
        .o_clearing (clearing)
    );

    spa_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_rdata     (rdata),
        .i_clearing  (clearing),
        .i_take      (take),
        .o_mem_req   (mem_req),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // Output register: free, or emptied this cycle
    assign take = !r_out_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid && take) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
        if (res_valid && take) begin
            r_out <= res;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.status         = r_out.status;
    assign o_out.block_address  = r_out.block_address;
    assign o_out.block_bytes    = r_out.block_bytes;
    assign o_out.top_word       = r_out.top_word;
    assign o_out.live_bytes     = r_out.live_bytes;
    assign o_out.reserved_bytes = r_out.reserved_bytes;

endmodule
`default_nettype wire
